// ===== hw/rtl/pidw_pkg.sv =====
// shared types, widths, constants and the control program of the pid block
package pidw_pkg;

  // loop rate in hertz, fixed at build time (range 1 to 100000)
  localparam int unsigned LOOP_RATE_HZ = 60;

  // data widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned RAW_W     = DATA_W + 2;
  localparam int unsigned RANGE_W   = DATA_W + 1;
  localparam int unsigned ERR_W     = DATA_W + 3;
  localparam int unsigned MUL_OP_W  = DATA_W + 1;
  localparam int unsigned MUL_W     = 2 * DATA_W;
  localparam int unsigned TERM_W    = MUL_W - FRAC_W;
  localparam int unsigned INTEG_W   = TERM_W + 1;
  localparam int unsigned DACC_W    = 50;
  localparam int unsigned DSUM_W    = DACC_W + FRAC_W + 1;
  localparam int unsigned D_LIM_LOG2 = 50;
  localparam int unsigned DTERM_W   = D_LIM_LOG2 + 2;
  localparam int unsigned TOT_W     = DTERM_W + 2;

  // constant divider: restoring, DIV_BITS quotient bits per cycle
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_ITERS = TERM_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS + 1);
  localparam int unsigned REM_W     = $clog2(LOOP_RATE_HZ + 1);
  localparam logic [REM_W:0] DIV_CONST = (REM_W + 1)'(LOOP_RATE_HZ);

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_UPPER  = 3'd3,
    REG_OUT_LOWER  = 3'd4,
    REG_WRAP_UPPER = 3'd5,
    REG_WRAP_LOWER = 3'd6,
    REG_WRAP_ON    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic signed [DATA_W-1:0] out_upper;
    logic signed [DATA_W-1:0] out_lower;
    logic signed [DATA_W-1:0] wrap_upper;
    logic signed [DATA_W-1:0] wrap_lower;
    logic                     wrap_on;
  } cfg_t;

  // channel payloads
  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
  } out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIFF,
    OP_WRAP,
    OP_DIV_LOAD,
    OP_PTERM,
    OP_SAVE_LO,
    OP_DHI,
    OP_DSUM,
    OP_DIV,
    OP_INTEG,
    OP_SUM,
    OP_EMIT
  } op_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_I,
    MUL_P,
    MUL_D,
    MUL_DH,
    MUL_DL
  } mul_e;

  // hold conditions: the step repeats while the condition is true
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_IN,
    HOLD_DIV,
    HOLD_OUT_BUSY
  } hold_e;

  localparam int unsigned PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_START = '0;

  typedef struct packed {
    op_e   op;
    mul_e  mul;
    hold_e hold;
    logic  jump;
    pc_t   target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_last;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t uword(op_e op, mul_e mul, hold_e hold, logic jump);
    ctrl_t w;
    w.op     = op;
    w.mul    = mul;
    w.hold   = hold;
    w.jump   = jump;
    w.target = PC_START;
    return w;
  endfunction

  // control program, one word per step
  function automatic ctrl_t ucode_word(pc_t pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = uword(OP_ACCEPT,   MUL_NONE, HOLD_NO_IN,    1'b0);
      4'd1:    w = uword(OP_DIFF,     MUL_NONE, HOLD_NONE,     1'b0);
      4'd2:    w = uword(OP_WRAP,     MUL_NONE, HOLD_NONE,     1'b0);
      4'd3:    w = uword(OP_NOP,      MUL_I,    HOLD_NONE,     1'b0);
      4'd4:    w = uword(OP_DIV_LOAD, MUL_P,    HOLD_NONE,     1'b0);
      4'd5:    w = uword(OP_PTERM,    MUL_D,    HOLD_NONE,     1'b0);
      4'd6:    w = uword(OP_SAVE_LO,  MUL_DH,   HOLD_NONE,     1'b0);
      4'd7:    w = uword(OP_DHI,      MUL_DL,   HOLD_NONE,     1'b0);
      4'd8:    w = uword(OP_DSUM,     MUL_NONE, HOLD_NONE,     1'b0);
      4'd9:    w = uword(OP_DIV,      MUL_NONE, HOLD_DIV,      1'b0);
      4'd10:   w = uword(OP_INTEG,    MUL_NONE, HOLD_NONE,     1'b0);
      4'd11:   w = uword(OP_SUM,      MUL_NONE, HOLD_NONE,     1'b0);
      4'd12:   w = uword(OP_EMIT,     MUL_NONE, HOLD_OUT_BUSY, 1'b1);
      default: w = uword(OP_NOP,      MUL_NONE, HOLD_NONE,     1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/pidw_in_if.sv =====
// input channel: setpoint and measurement with valid/ready
interface pidw_in_if;
  import pidw_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pidw_out_if.sv =====
// output channel: controller drive with valid/ready
interface pidw_out_if;
  import pidw_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pidw_divider.sv =====
// floor division by the loop rate, DIV_BITS quotient bits per cycle while step_i is high
module pidw_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic                               step_i,
  input  logic        [pidw_pkg::TERM_W-1:0] num_i,
  input  logic                               neg_i,
  output logic signed [pidw_pkg::TERM_W-1:0] quot_o,
  output logic                               last_o
);
  import pidw_pkg::*;

  logic [TERM_W-1:0]    num_q, num_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q;
  logic [REM_W:0]       trial;

  // restoring steps on the non-negative dividend, quotient bits shift in from the bottom
  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_d, num_d[TERM_W-1]};
      num_d = {num_d[TERM_W-2:0], 1'b0};
      if (trial >= DIV_CONST) begin
        rem_d    = REM_W'(trial - DIV_CONST);
        num_d[0] = 1'b1;
      end else begin
        rem_d = trial[REM_W-1:0];
      end
    end
  end

  // negative dividends go in and out as ones' complement, which floors
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= neg_i ? ~num_i : num_i;
      neg_q <= neg_i;
      rem_q <= '0;
    end else if (step_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  assign quot_o = $signed(neg_q ? ~num_q : num_q);
  assign last_o = (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));

`ifndef SYNTHESIS
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> cnt_q < DIV_CNT_W'(DIV_ITERS))
    else $error("divider stepped past its last iteration");
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q == '0)
    else $error("divider load did not restart the count");
  a_load_step_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load_i && step_i))
    else $error("divider loaded and stepped in one cycle");
`endif

endmodule

// ===== hw/rtl/pidw_sequencer.sv =====
// step counter and control store with hold and jump handling
module pidw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pidw_pkg::stat_t stat_i,
  output pidw_pkg::ctrl_t ctrl_o,
  output logic            adv_o
);
  import pidw_pkg::*;

  pc_t   pc_q, pc_d;
  ctrl_t ctrl;
  logic  held;

  // fetch the control word
  assign ctrl = ucode_word(pc_q);

  // hold condition and next step
  always_comb begin
    case (ctrl.hold)
      HOLD_NO_IN:    held = !stat_i.in_valid;
      HOLD_DIV:      held = !stat_i.div_last;
      HOLD_OUT_BUSY: held = stat_i.out_busy;
      default:       held = 1'b0;
    endcase
    if (held) begin
      pc_d = pc_q;
    end else if (ctrl.jump) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_START;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign adv_o  = !held;

endmodule

// ===== hw/rtl/pidw_datapath.sv =====
// working registers, shared multiplier, adders and clamps of the pid block
module pidw_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pidw_pkg::ctrl_t                    ctrl_i,
  input  logic                               adv_i,
  input  pidw_pkg::cfg_t                     cfg_i,
  input  pidw_pkg::in_t                      in_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output pidw_pkg::out_t                     out_data_o,
  output logic                               div_last_o,
  output logic                               out_busy_o
);
  import pidw_pkg::*;

  // wrap once, then saturate to the 32-bit range
  function automatic logic signed [DATA_W-1:0] wrap_sat(
    input logic signed [RAW_W-1:0]   v,
    input logic signed [RANGE_W-1:0] rng,
    input cfg_t                      c
  );
    logic signed [ERR_W-1:0] w;
    logic signed [DATA_W-1:0] r;
    w = ERR_W'(v);
    if (c.wrap_on) begin
      if (w > ERR_W'(c.wrap_upper)) begin
        w = w - ERR_W'(rng);
      end else if (w < ERR_W'(c.wrap_lower)) begin
        w = w + ERR_W'(rng);
      end
    end
    if (!w[ERR_W-1] && (|w[ERR_W-2:DATA_W-1])) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (w[ERR_W-1] && !(&w[ERR_W-2:DATA_W-1])) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = w[DATA_W-1:0];
    end
    return r;
  endfunction

  localparam logic signed [MUL_OP_W-1:0] RATE_OP = MUL_OP_W'(LOOP_RATE_HZ);
  localparam logic signed [DSUM_W-1:0] D_POS =
    {{(DSUM_W-D_LIM_LOG2-1){1'b0}}, 1'b1, {D_LIM_LOG2{1'b0}}};
  localparam logic signed [DSUM_W-1:0] D_NEG = -D_POS;

  logic signed [DATA_W-1:0]  tgt_q, meas_q, last_q, err_q, dif_q, integ_q, drive_q;
  logic signed [RAW_W-1:0]   err_raw_q, dif_raw_q, raw_err, raw_dif;
  logic signed [RANGE_W-1:0] range_q, rng;
  logic signed [MUL_W-1:0]   mul_q, mul_d;
  logic        [DATA_W-1:0]  lo_q;
  logic signed [TERM_W-1:0]  pterm_q, quot;
  logic signed [DACC_W-1:0]  dacc_q;
  logic signed [DTERM_W-1:0] dterm_q, dterm_d;
  logic signed [TOT_W-1:0]   tot_q, tot_d, tot_c;
  logic signed [INTEG_W-1:0] integ_sum;
  logic signed [DATA_W-1:0]  integ_d, drive_d;
  logic signed [DSUM_W-1:0]  dsum;
  logic signed [MUL_OP_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_OP_W-1:0] prod;
  logic                      out_valid_q;
  logic                      div_load, div_step;

  // error, difference and wrap range
  assign raw_err = RAW_W'(tgt_q) - RAW_W'(meas_q);
  assign raw_dif = RAW_W'(meas_q) - RAW_W'(last_q);
  assign rng     = RANGE_W'(cfg_i.wrap_upper) - RANGE_W'(cfg_i.wrap_lower);

  // shared multiplier operand select
  always_comb begin
    case (ctrl_i.mul)
      MUL_I: begin
        mul_a = MUL_OP_W'(cfg_i.integ_gain);
        mul_b = MUL_OP_W'(err_q);
      end
      MUL_P: begin
        mul_a = MUL_OP_W'(cfg_i.prop_gain);
        mul_b = MUL_OP_W'(err_q);
      end
      MUL_D: begin
        mul_a = MUL_OP_W'(cfg_i.deriv_gain);
        mul_b = MUL_OP_W'(dif_q);
      end
      MUL_DH: begin
        mul_a = MUL_OP_W'($signed(mul_q[MUL_W-1:DATA_W]));
        mul_b = RATE_OP;
      end
      MUL_DL: begin
        mul_a = $signed({1'b0, lo_q});
        mul_b = RATE_OP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod  = mul_a * mul_b;
    mul_d = prod[MUL_W-1:0];
  end

  // integral update with upper then lower clamp
  always_comb begin
    integ_sum = INTEG_W'(quot) + INTEG_W'(integ_q);
    if (integ_sum > INTEG_W'(cfg_i.out_upper)) begin
      integ_sum = INTEG_W'(cfg_i.out_upper);
    end
    if (integ_sum < INTEG_W'(cfg_i.out_lower)) begin
      integ_sum = INTEG_W'(cfg_i.out_lower);
    end
    integ_d = integ_sum[DATA_W-1:0];
  end

  // derivative: (hi*rate << 32 + lo*rate) >> 16, limited
  always_comb begin
    dsum = (DSUM_W'(dacc_q) <<< FRAC_W) + DSUM_W'(mul_q[MUL_W-1:FRAC_W]);
    if (dsum > D_POS) begin
      dsum = D_POS;
    end
    if (dsum < D_NEG) begin
      dsum = D_NEG;
    end
    dterm_d = dsum[DTERM_W-1:0];
  end

  // output sum and clamp
  assign tot_d = TOT_W'(pterm_q) + TOT_W'(integ_q) + TOT_W'(dterm_q);

  always_comb begin
    tot_c = tot_q;
    if (tot_c > TOT_W'(cfg_i.out_upper)) begin
      tot_c = TOT_W'(cfg_i.out_upper);
    end
    if (tot_c < TOT_W'(cfg_i.out_lower)) begin
      tot_c = TOT_W'(cfg_i.out_lower);
    end
    drive_d = tot_c[DATA_W-1:0];
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_ACCEPT: begin
        if (adv_i) begin
          tgt_q  <= in_data_i.target;
          meas_q <= in_data_i.measured;
        end
      end
      OP_DIFF: begin
        err_raw_q <= raw_err;
        dif_raw_q <= raw_dif;
        range_q   <= rng;
      end
      OP_WRAP: begin
        err_q <= wrap_sat(err_raw_q, range_q, cfg_i);
        dif_q <= wrap_sat(dif_raw_q, range_q, cfg_i);
      end
      OP_PTERM:   pterm_q <= $signed(mul_q[MUL_W-1:FRAC_W]);
      OP_SAVE_LO: lo_q    <= mul_q[DATA_W-1:0];
      OP_DHI:     dacc_q  <= $signed(mul_q[DACC_W-1:0]);
      OP_DSUM:    dterm_q <= dterm_d;
      OP_SUM:     tot_q   <= tot_d;
      OP_EMIT: begin
        if (adv_i) begin
          drive_q <= drive_d;
        end
      end
      default: ;
    endcase
    if (ctrl_i.mul != MUL_NONE) begin
      mul_q <= mul_d;
    end
  end

  // loop state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      integ_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_DIFF) begin
        last_q <= meas_q;
      end
      if (ctrl_i.op == OP_INTEG) begin
        integ_q <= integ_d;
      end
      if (ctrl_i.op == OP_EMIT && adv_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // integral increment divided by the loop rate
  assign div_load = (ctrl_i.op == OP_DIV_LOAD);
  assign div_step = (ctrl_i.op == OP_DIV);

  pidw_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (div_load),
    .step_i (div_step),
    .num_i  (mul_q[MUL_W-1:FRAC_W]),
    .neg_i  (mul_q[MUL_W-1]),
    .quot_o (quot),
    .last_o (div_last_o)
  );

  assign out_valid_o      = out_valid_q;
  assign out_data_o.drive = drive_q;
  assign out_busy_o       = out_valid_q && !out_ready_i;

endmodule

// ===== hw/rtl/pid_controller_with_angle_wrap.sv =====
// top level of the pid controller with angle wrap
//
// Usage: one transaction on in_i carries a setpoint (target) and a
// measurement (measured), both signed Q16.16. Each accepted transaction
// produces exactly one transaction on out_o carrying the clamped drive.
// Gains, limits and wrap settings are written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i while the block is idle; there is no read-back.
// The result of one input is computed by the microcode program before the
// next input is taken, so inputs do not overlap. The program has thirteen
// steps on one shared 33x33 multiplier; all of them run without holding but
// the input step, the emit step and the division of the integral increment
// by the loop rate, which repeats at 4 quotient bits per cycle until its
// last iteration.
// The drive sits in an output register; if the receiver stalls, the next
// input is still accepted and computed, and the sequencer waits at its
// final step until the previous result has been taken.
// Reset clears all gains and limits, the integral and the previous
// measurement to zero, and drops out_o.valid.
module pid_controller_with_angle_wrap (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  pidw_in_if.sink                              in_i,
  pidw_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic        [pidw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [pidw_pkg::DATA_W-1:0]   cfg_wdata_i
);
  import pidw_pkg::*;

  cfg_t  cfg_q;
  ctrl_t ctrl;
  stat_t stat;
  logic  adv;
  logic  div_last, out_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:  cfg_q.prop_gain  <= $signed(cfg_wdata_i);
        REG_INTEG_GAIN: cfg_q.integ_gain <= $signed(cfg_wdata_i);
        REG_DERIV_GAIN: cfg_q.deriv_gain <= $signed(cfg_wdata_i);
        REG_OUT_UPPER:  cfg_q.out_upper  <= $signed(cfg_wdata_i);
        REG_OUT_LOWER:  cfg_q.out_lower  <= $signed(cfg_wdata_i);
        REG_WRAP_UPPER: cfg_q.wrap_upper <= $signed(cfg_wdata_i);
        REG_WRAP_LOWER: cfg_q.wrap_lower <= $signed(cfg_wdata_i);
        REG_WRAP_ON:    cfg_q.wrap_on    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // status back to the sequencer
  always_comb begin
    stat.in_valid = in_i.valid;
    stat.div_last = div_last;
    stat.out_busy = out_busy;
  end

  pidw_sequencer u_sequencer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .adv_o  (adv)
  );

  pidw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .div_last_o  (div_last),
    .out_busy_o  (out_busy)
  );

  // input is taken only at the first program step
  assign in_i.ready = (ctrl.op == OP_ACCEPT);

`ifndef SYNTHESIS
  a_accept_then_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> ctrl.op == OP_DIFF)
    else $error("accepted transaction not followed by the difference step");
  a_integ_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == OP_INTEG |-> $past(ctrl.op == OP_DIV) && $past(div_last))
    else $error("integral updated before the division finished");
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("output valid raised outside the emit step");
  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == OP_EMIT && out_busy |=> ctrl.op == OP_EMIT)
    else $error("emit step left while the previous result was pending");
`endif

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the pid controller with angle wrap: predicted drive vs. the block's output
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidw_pkg::*;

  localparam int unsigned LATENCY     = 24;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PER_PHASE   = 161;

  // Q16.16 helpers
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_PI   = 32'd205887;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  // predictor arithmetic constants
  localparam longint FRAC_SCALE = 64'sd65536;
  localparam longint RATE       = longint'(LOOP_RATE_HZ);
  localparam longint D_CAP      = 64'sd1125899906842624;
  localparam longint I32_TOP    = 64'sh7FFF_FFFF;
  localparam longint I32_BOT    = -64'sh8000_0000;

  // expected drive tracker: own copy of gains, limits and loop state
  class drive_tracker;
    longint kp, ki, kd, lim_hi, lim_lo, wrap_hi, wrap_lo;
    bit     wrap_en;
    longint integ, prev_meas;
    logic [31:0] drive_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      kp = 0; ki = 0; kd = 0; lim_hi = 0; lim_lo = 0; wrap_hi = 0; wrap_lo = 0;
      wrap_en = 1'b0;
      integ = 0; prev_meas = 0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_PROP_GAIN:  kp = longint'($signed(val));
        REG_INTEG_GAIN: ki = longint'($signed(val));
        REG_DERIV_GAIN: kd = longint'($signed(val));
        REG_OUT_UPPER:  lim_hi = longint'($signed(val));
        REG_OUT_LOWER:  lim_lo = longint'($signed(val));
        REG_WRAP_UPPER: wrap_hi = longint'($signed(val));
        REG_WRAP_LOWER: wrap_lo = longint'($signed(val));
        REG_WRAP_ON:    wrap_en = val[0];
        default: ;
      endcase
    endfunction

    function longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q -= 1;
      return q;
    endfunction

    function longint sat32(longint v);
      if (v > I32_TOP) return I32_TOP;
      if (v < I32_BOT) return I32_BOT;
      return v;
    endfunction

    function longint wrap_angle(longint v, longint range);
      if (!wrap_en) return v;
      if (v > wrap_hi) return v - range;
      if (v < wrap_lo) return v + range;
      return v;
    endfunction

    // upper limit first, then lower
    function longint clamp_lim(longint v);
      if (v > lim_hi) v = lim_hi;
      if (v < lim_lo) v = lim_lo;
      return v;
    endfunction

    function logic [31:0] predict_drive(longint tgt, longint meas);
      longint range, err, dif, pterm, dterm, prod, q, r, total;
      range = wrap_hi - wrap_lo;
      err = sat32(wrap_angle(tgt - meas, range));
      dif = sat32(wrap_angle(meas - prev_meas, range));
      prev_meas = meas;
      integ = clamp_lim(integ + floor_div(ki * err, FRAC_SCALE * RATE));
      pterm = floor_div(kp * err, FRAC_SCALE);
      // derivative times rate, floored exactly
      prod = kd * dif;
      q = floor_div(prod, FRAC_SCALE);
      r = prod - q * FRAC_SCALE;
      dterm = q * RATE + (r * RATE) / FRAC_SCALE;
      if (dterm > D_CAP) dterm = D_CAP;
      if (dterm < -D_CAP) dterm = -D_CAP;
      total = clamp_lim(pterm + integ + dterm);
      return total[31:0];
    endfunction

    function void note_input(in_t item);
      drive_q.push_back(predict_drive(longint'($signed(item.target)),
                                      longint'($signed(item.measured))));
    endfunction

    function void check_drive(out_t got);
      logic [31:0] want;
      if (drive_q.size() == 0) begin
        $display("%0t: drive %h arrived with none expected", $time, got.drive);
        errors++;
        return;
      end
      want = drive_q.pop_front();
      checked++;
      if (got.drive !== want) begin
        $display("%0t: drive mismatch, expected %h, actual %h", $time, want, got.drive);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0] cfg_wdata;

  pidw_in_if  in_ch();
  pidw_out_if out_ch();

  drive_tracker sb;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int unsigned holds_done = 0;
  int unsigned items_sent = 0;
  int unsigned phases = 0;
  int unsigned idle_cycles = 0;
  logic signed [31:0] last_meas = '0;
  logic signed [31:0] setpoint = '0;

  pid_controller_with_angle_wrap u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] rand_span(int unsigned span);
    int offs;
    offs = int'($urandom_range(0, 2 * span));
    return offs - int'(span);
  endfunction

  function automatic logic [31:0] pick_edge();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return NEG_MAX;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hFFFF_FFFF;
      default: return Q_ONE;
    endcase
  endfunction

  // register settings for one random phase
  function automatic cfg_t make_config(int unsigned style);
    cfg_t c;
    logic signed [31:0] lim, bound;
    lim = $urandom_range(65536, 13107200);
    bound = $urandom_range(65536, 262144);
    c.prop_gain  = rand_span(262144);
    c.integ_gain = rand_span(262144);
    c.deriv_gain = rand_span(262144);
    c.out_upper  = lim;
    c.out_lower  = -$signed(32'($urandom_range(65536, 13107200)));
    c.wrap_upper = bound;
    c.wrap_lower = -bound;
    c.wrap_on    = $urandom_range(0, 1);
    case (style)
      1: begin
        c.prop_gain  = $urandom;
        c.integ_gain = $urandom;
        c.deriv_gain = $urandom;
        c.out_upper  = $urandom;
        c.out_lower  = $urandom;
        c.wrap_upper = $urandom;
        c.wrap_lower = $urandom;
      end
      2: begin
        c.prop_gain  = pick_edge();
        c.integ_gain = pick_edge();
        c.deriv_gain = pick_edge();
        c.out_upper  = POS_MAX;
        c.out_lower  = NEG_MAX;
        c.wrap_upper = pick_edge();
        c.wrap_lower = pick_edge();
      end
      3: begin
        // limits and wrap bounds reversed
        c.out_upper  = -lim;
        c.out_lower  = lim;
        c.wrap_upper = -bound;
        c.wrap_lower = bound;
        c.wrap_on    = 1'b1;
      end
      default: ;
    endcase
    return c;
  endfunction

  // one input transaction: half a loop tracking its setpoint, the rest noise, wrap-bound cases and edges
  function automatic in_t make_item(cfg_t c);
    in_t it;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 9) == 0) setpoint = rand_span(655360);
    it.target = setpoint + rand_span(4096);
    it.measured = last_meas + ((setpoint - last_meas) >>> 2) + rand_span(8192);
    case (pick)
      0, 1: begin
        it.target = $urandom;
        it.measured = $urandom;
      end
      7: begin
        it.measured = $urandom_range(0, 1) ? 32'sd0 : rand_span(65536);
        it.target = ($urandom_range(0, 1) ? c.wrap_upper : c.wrap_lower)
                    + it.measured + rand_span($urandom_range(0, 1) ? 2 : 65536);
      end
      8: begin
        it.target = pick_edge();
        it.measured = pick_edge();
      end
      9: begin
        it.target = rand_span(1310720);
        it.measured = rand_span(1310720);
      end
      default: ;
    endcase
    last_meas = it.measured;
    return it;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_PROP_GAIN, c.prop_gain);
    write_reg(REG_INTEG_GAIN, c.integ_gain);
    write_reg(REG_DERIV_GAIN, c.deriv_gain);
    write_reg(REG_OUT_UPPER, c.out_upper);
    write_reg(REG_OUT_LOWER, c.out_lower);
    write_reg(REG_WRAP_UPPER, c.wrap_upper);
    write_reg(REG_WRAP_LOWER, c.wrap_lower);
    write_reg(REG_WRAP_ON, {31'b0, c.wrap_on});
    cfg_we <= 1'b0;
    phases++;
  endtask

  // offer one transaction after a random gap, return once it is taken
  task automatic send_item(in_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(item);
    items_sent++;
  endtask

  task automatic send_pair(logic [31:0] tgt, logic [31:0] meas);
    in_t it;
    it.target = tgt;
    it.measured = meas;
    send_item(it);
  endtask

  // drop valid and wait until every drive is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: checks drives, stalls at random, plus requested long hold-offs
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_drive(out_ch.data);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        holds_done++;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_PROP_GAIN;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: all gains and limits zero
    send_pair(POS_MAX, 32'd5);
    send_pair(NEG_MAX, POS_MAX);
    drain();

    // wrap at +-pi, moderate gains
    c = '{prop_gain: Q_ONE, integ_gain: 32'h0002_0000, deriv_gain: 32'h0000_8000,
          out_upper: 32'd6553600, out_lower: -32'sd6553600,
          wrap_upper: Q_PI, wrap_lower: -$signed(Q_PI), wrap_on: 1'b1};
    load_config(c);
    send_pair(32'd0, 32'd0);
    send_pair(32'd185298, -32'sd185298);
    send_pair(-32'sd185298, 32'd185298);
    send_pair(POS_MAX, NEG_MAX);
    send_pair(NEG_MAX, POS_MAX);
    send_pair(POS_MAX, POS_MAX);
    send_pair(NEG_MAX, NEG_MAX);
    drain();

    // extreme gains, full range limits, no wrap; large derivative
    c = '{prop_gain: POS_MAX, integ_gain: NEG_MAX, deriv_gain: POS_MAX,
          out_upper: POS_MAX, out_lower: NEG_MAX,
          wrap_upper: 32'd0, wrap_lower: 32'd0, wrap_on: 1'b0};
    load_config(c);
    send_pair(32'd1, 32'd0);
    send_pair(POS_MAX, NEG_MAX);
    send_pair(32'd0, POS_MAX);
    send_pair(NEG_MAX, NEG_MAX);
    send_pair(32'h1234_5678, 32'h0F0F_0F0F);
    drain();

    // reversed limits and reversed wrap bounds
    c = '{prop_gain: Q_ONE, integ_gain: 32'h0000_4000, deriv_gain: 32'd0,
          out_upper: -32'sd655360, out_lower: 32'd655360,
          wrap_upper: -$signed(Q_PI), wrap_lower: Q_PI, wrap_on: 1'b1};
    load_config(c);
    send_pair(32'd327680, 32'd0);
    send_pair(-32'sd1310720, 32'd0);
    send_pair(32'd0, 32'd0);
    send_pair(32'd1310720, -32'sd1310720);
    send_pair(POS_MAX, NEG_MAX);
    drain();

    // widest wrap range, negative gains
    c = '{prop_gain: -$signed(Q_ONE), integ_gain: -32'sd4096, deriv_gain: NEG_MAX,
          out_upper: POS_MAX, out_lower: NEG_MAX,
          wrap_upper: POS_MAX, wrap_lower: NEG_MAX, wrap_on: 1'b1};
    load_config(c);
    send_pair(POS_MAX, NEG_MAX);
    send_pair(NEG_MAX, POS_MAX);
    send_pair(32'h4000_0000, 32'hC000_0000);
    send_pair(32'hFFFF_FFFF, 32'd1);
    drain();

    // random phases, each under its own register settings
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      c = make_config(ph % 4);
      load_config(c);
      no_gaps = (ph == 3 || ph == 8);
      if (ph == 2 || ph == 9) hold_req = 1'b1;
      for (int unsigned n = 0; n < PER_PHASE; n++) begin
        send_item(make_item(c));
      end
      drain();
    end
    no_gaps = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d transactions under %0d register settings, %0d drives checked",
             items_sent, phases, sb.checked);
    $display("wrap, reversed bounds, clamp and gain extremes included; %0d long hold-offs",
             holds_done);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected drives never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
